// File: hdl/sdir_pkg.sv
// shared types, codes and default sizes of the slot directory
`default_nettype none

package sdir_pkg;

  localparam int unsigned DefMaxSlots = 256;
  localparam int unsigned DefPageBytes = 4096;

  localparam int unsigned KindW = 2;
  localparam int unsigned PosW = 9;
  localparam int unsigned OfsW = 12;
  localparam int unsigned CntW = 9;
  localparam int unsigned DirW = 13;
  localparam int unsigned StatusW = 2;

  typedef enum logic [KindW-1:0] {
    KIND_READ   = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_REMOVE = 2'd2
  } sdir_kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } sdir_status_e;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [PosW-1:0]  position;
    logic [OfsW-1:0]  rec_ofs;
  } sdir_req_t;

  typedef struct packed {
    logic [OfsW-1:0]    slot_offset;
    logic [CntW-1:0]    slot_count;
    logic [DirW-1:0]    directory_start;
    logic [StatusW-1:0] status;
  } sdir_rsp_t;

  // control broadcast from the top level to every cell
  typedef struct packed {
    logic            ins;
    logic            rem;
    logic [PosW-1:0] pos;
    logic [OfsW-1:0] rec;
  } sdir_cell_ctrl_t;

endpackage

`default_nettype wire

// File: hdl/sdir_stream_if.sv
// valid/ready stream interface carrying one payload beat
`default_nettype none

interface sdir_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

`default_nettype wire

// File: hdl/sdir_cell.sv
// one slot of the directory, shifting with its neighbours on insert and remove
`default_nettype none

module sdir_cell #(
  parameter int unsigned Idx = 0
) (
  input  wire                          clk_i,
  input  sdir_pkg::sdir_cell_ctrl_t    ctrl_i,
  input  wire  [sdir_pkg::OfsW-1:0]    left_i,
  input  wire  [sdir_pkg::OfsW-1:0]    right_i,
  output logic [sdir_pkg::OfsW-1:0]    value_o
);
  import sdir_pkg::*;

  logic [OfsW-1:0] value_q, value_d;
  logic            at_pos, after_pos;

  assign at_pos    = (32'(ctrl_i.pos) == Idx);
  assign after_pos = (32'(ctrl_i.pos) < Idx);

  always_comb begin
    value_d = value_q;
    if (ctrl_i.ins && at_pos) begin
      value_d = ctrl_i.rec;
    end else if (ctrl_i.ins && after_pos) begin
      value_d = left_i;
    end else if (ctrl_i.rem && (at_pos || after_pos)) begin
      value_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

`default_nettype wire

// File: hdl/slot_directory_insert_remove.sv
// top level: slot directory of a slotted page as a row of shifting cells
//
// req_i takes one beat per item: kind (read, insert, remove), position and
// record offset. rsp_o returns exactly one beat per item with the read
// offset, the slot count and directory start after the item, and a status.
// Every item is decoded against the current count in the cycle it is taken,
// the whole row of slot cells shifts in that same cycle, and the result sits
// in the output register on the next edge; one item per cycle is sustained
// while rsp_o is ready. The read path is a MAX_SLOTS-way select over the cells.
// req_i.ready stays high while the output register is empty or being
// drained, so a stalled receiver holds one result and blocks further input
// only while that result is waiting.
// Reset empties the directory (count zero, start at PAGE_BYTES); the slot
// cells are not cleared, slots above the count are unused.
// Rejected items (position out of range, insert into a full directory)
// change no state.
`default_nettype none

module slot_directory_insert_remove #(
  parameter int unsigned MAX_SLOTS  = sdir_pkg::DefMaxSlots,
  parameter int unsigned PAGE_BYTES = sdir_pkg::DefPageBytes
) (
  input  wire   clk_i,
  input  wire   rst_ni,
  sdir_stream_if.sink   req_i,
  sdir_stream_if.source rsp_o
);
  import sdir_pkg::*;

  localparam int unsigned CW   = $clog2(MAX_SLOTS + 1);
  localparam int unsigned IW   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned CMPW = (CW > PosW) ? CW : PosW;
  localparam int unsigned DWP  = $clog2(PAGE_BYTES + 1);
  localparam int unsigned DW   = (DWP > DirW) ? DWP : DirW;

  logic [CW-1:0]   count_q, count_d;
  logic [DW-1:0]   dir_q, dir_d;
  sdir_rsp_t       rsp_q, rsp_d;
  logic            rsp_valid_q;

  logic            req_acc;
  logic [CMPW-1:0] pos_x, cnt_x;
  logic            full;
  logic [OfsW-1:0] rd_val;
  sdir_cell_ctrl_t ctrl;

  logic [OfsW-1:0] cell_val [MAX_SLOTS];

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign req_acc     = req_i.valid && req_i.ready;

  assign pos_x  = CMPW'(req_i.data.position);
  assign cnt_x  = CMPW'(count_q);
  assign full   = (32'(count_q) >= MAX_SLOTS);
  assign rd_val = cell_val[pos_x[IW-1:0]];

  // decode the item against the current count
  always_comb begin
    ctrl.ins = 1'b0;
    ctrl.rem = 1'b0;
    ctrl.pos = req_i.data.position;
    ctrl.rec = req_i.data.rec_ofs;
    count_d  = count_q;
    dir_d    = dir_q;
    rsp_d.slot_offset = '0;
    rsp_d.status      = ST_OK;
    unique case (req_i.data.kind)
      KIND_READ: begin
        if (pos_x < cnt_x) begin
          rsp_d.slot_offset = rd_val;
        end else begin
          rsp_d.status = ST_RANGE;
        end
      end
      KIND_INSERT: begin
        if (full) begin
          rsp_d.status = ST_FULL;
        end else if (pos_x > cnt_x) begin
          rsp_d.status = ST_RANGE;
        end else begin
          ctrl.ins = req_acc;
          count_d  = count_q + CW'(1);
          dir_d    = dir_q - DW'(2);
        end
      end
      KIND_REMOVE: begin
        if (pos_x >= cnt_x) begin
          rsp_d.status = ST_RANGE;
        end else begin
          ctrl.rem = req_acc;
          count_d  = count_q - CW'(1);
          dir_d    = dir_q + DW'(2);
        end
      end
      default: begin
      end
    endcase
    rsp_d.slot_count      = CntW'(count_d);
    rsp_d.directory_start = DirW'(dir_d);
  end

  for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cell
    logic [OfsW-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_inner_l
      assign left = cell_val[i-1];
    end
    if (i == MAX_SLOTS - 1) begin : g_last
      assign right = cell_val[i];
    end else begin : g_inner_r
      assign right = cell_val[i+1];
    end
    sdir_cell #(
      .Idx (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .left_i  (left),
      .right_i (right),
      .value_o (cell_val[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      dir_q       <= DW'(PAGE_BYTES);
      rsp_valid_q <= 1'b0;
    end else begin
      if (req_acc) begin
        count_q     <= count_d;
        dir_q       <= dir_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  // directory never holds more than its capacity
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= MAX_SLOTS)
    else $error("slot count above capacity");

  // start of the directory tracks two bytes per slot, modulo its width
  a_dir_tracks_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dir_q + DW'(2 * 32'(count_q))) == DW'(PAGE_BYTES))
    else $error("directory start out of step with slot count");

  // an insert into a full directory leaves the count alone
  a_full_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && (req_i.data.kind == KIND_INSERT) && full) |=> $stable(count_q))
    else $error("insert into full directory changed the count");

  // an input beat is taken only when the result register can take its result
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && !rsp_o.ready) |-> !req_acc)
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire

// File: tb/slot_directory_insert_remove_tb.sv
// testbench for the slot directory: random and directed items checked against a scoreboard
`default_nettype none

module slot_directory_insert_remove_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sdir_pkg::*;

  localparam int unsigned MaxSlots  = DefMaxSlots;
  localparam int unsigned PageBytes = DefPageBytes;
  localparam logic [KindW-1:0] KindUnused = 2'd3;
  localparam int unsigned IdleLimit  = 2000;
  localparam int unsigned PhaseItems = 170;
  localparam int unsigned MaxPrinted = 40;

  // directory contents and expected result beats, in acceptance order
  class slot_dir_scoreboard;
    logic [OfsW-1:0] slots [MaxSlots];
    int unsigned     used;
    int unsigned     dir_begin;
    sdir_rsp_t       due_rsp [$];
    int unsigned     mismatches;

    function new();
      foreach (slots[i]) slots[i] = '0;
      used       = 0;
      dir_begin  = PageBytes;
      mismatches = 0;
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      if (mismatches < MaxPrinted)
        $display("mismatch: %s got 0x%0h want 0x%0h at %0t", what, got, want, $realtime);
      mismatches++;
    endtask

    function void note_request(sdir_req_t item);
      sdir_rsp_t   want;
      int unsigned pos;
      pos  = item.position;
      want = '0;
      want.status = ST_OK;
      case (item.kind)
        KIND_READ: begin
          if (pos < used) want.slot_offset = slots[pos];
          else want.status = ST_RANGE;
        end
        KIND_INSERT: begin
          // full is checked ahead of the position
          if (used >= MaxSlots) begin
            want.status = ST_FULL;
          end else if (pos > used) begin
            want.status = ST_RANGE;
          end else begin
            for (int i = used; i > pos; i--) slots[i] = slots[i-1];
            slots[pos] = item.rec_ofs;
            used++;
            dir_begin -= 2;
          end
        end
        KIND_REMOVE: begin
          if (pos >= used) begin
            want.status = ST_RANGE;
          end else begin
            for (int i = pos + 1; i < used; i++) slots[i-1] = slots[i];
            used--;
            dir_begin += 2;
          end
        end
        default: ;
      endcase
      want.slot_count      = used[CntW-1:0];
      want.directory_start = dir_begin[DirW-1:0];
      due_rsp.push_back(want);
    endfunction

    task check_response(sdir_rsp_t got);
      sdir_rsp_t want;
      if (due_rsp.size() == 0) begin
        report("unexpected result beat", 64'(got), '0);
        return;
      end
      want = due_rsp.pop_front();
      if (got.slot_offset !== want.slot_offset)
        report("slot_offset", 64'(got.slot_offset), 64'(want.slot_offset));
      if (got.slot_count !== want.slot_count)
        report("slot_count", 64'(got.slot_count), 64'(want.slot_count));
      if (got.directory_start !== want.directory_start)
        report("directory_start", 64'(got.directory_start), 64'(want.directory_start));
      if (got.status !== want.status)
        report("status", 64'(got.status), 64'(want.status));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  sdir_stream_if #(.payload_t(sdir_req_t)) req_if ();
  sdir_stream_if #(.payload_t(sdir_rsp_t)) rsp_if ();

  slot_directory_insert_remove #(
    .MAX_SLOTS (MaxSlots),
    .PAGE_BYTES(PageBytes)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  slot_dir_scoreboard dir_board = new();

  int unsigned src_idle_pct  = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned idle_cycles   = 0;

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    rsp_if.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) dir_board.check_response(rsp_if.data);
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IdleLimit) begin
        $display("timeout: no beat for %0d cycles", IdleLimit);
        $display("slot_directory_insert_remove_tb: FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic sdir_req_t make_req(logic [KindW-1:0] kind, int unsigned pos,
                                         logic [OfsW-1:0] ofs);
    sdir_req_t item;
    item.kind     = kind;
    item.position = pos[PosW-1:0];
    item.rec_ofs  = ofs;
    return item;
  endfunction

  // mostly well-formed items against the current count, a little noise
  function automatic sdir_req_t random_req(bit growing);
    sdir_req_t   item;
    int unsigned roll;
    int unsigned n;
    n = dir_board.used;
    item.rec_ofs = OfsW'($urandom_range((1 << OfsW) - 1));
    roll = $urandom_range(99);
    if (roll < 5) begin
      item.kind     = KindW'($urandom_range(3));
      item.position = PosW'($urandom_range((1 << PosW) - 1));
    end else begin
      roll = $urandom_range(99);
      if ((growing && roll < 80) || (!growing && roll < 8)) begin
        item.kind     = KIND_INSERT;
        item.position = PosW'($urandom_range(n));
      end else begin
        if ((growing && roll < 90) || (!growing && roll < 25)) item.kind = KIND_READ;
        else item.kind = KIND_REMOVE;
        item.position = (n == 0) ? '0 : PosW'($urandom_range(n - 1));
      end
    end
    return item;
  endfunction

  task automatic send_req(sdir_req_t item);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= item;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    dir_board.note_request(item);
  endtask

  sdir_req_t directed [$];

  initial begin
    bit growing;
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty directory, front / middle / end, out of range, unknown kind
    directed.push_back(make_req(KIND_READ, 0, 0));
    directed.push_back(make_req(KIND_REMOVE, 0, 0));
    directed.push_back(make_req(KIND_INSERT, 1, 12'h123));
    directed.push_back(make_req(KindUnused, 511, 12'hfff));
    directed.push_back(make_req(KIND_INSERT, 0, 12'hfff));
    directed.push_back(make_req(KIND_INSERT, 0, 12'h000));
    directed.push_back(make_req(KIND_INSERT, 2, 12'habc));
    directed.push_back(make_req(KIND_INSERT, 1, 12'h555));
    directed.push_back(make_req(KIND_READ, 0, 0));
    directed.push_back(make_req(KIND_READ, 1, 0));
    directed.push_back(make_req(KIND_READ, 2, 0));
    directed.push_back(make_req(KIND_READ, 3, 12'hfff));
    directed.push_back(make_req(KIND_READ, 4, 0));
    directed.push_back(make_req(KIND_READ, 511, 0));
    directed.push_back(make_req(KIND_INSERT, 511, 12'h7ff));
    directed.push_back(make_req(KIND_REMOVE, 4, 0));
    directed.push_back(make_req(KIND_REMOVE, 1, 0));
    directed.push_back(make_req(KIND_REMOVE, 0, 0));
    directed.push_back(make_req(KIND_REMOVE, 1, 0));
    directed.push_back(make_req(KIND_READ, 0, 0));
    directed.push_back(make_req(KindUnused, 0, 0));
    directed.push_back(make_req(KIND_INSERT, 256, 12'h800));
    directed.push_back(make_req(KIND_REMOVE, 256, 0));
    foreach (directed[i]) send_req(directed[i]);

    growing = 1'b1;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 47; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 47; end
        default: begin src_idle_pct = 16; sink_stall_pct = 16; end
      endcase
      for (int k = 0; k < PhaseItems; k++) begin
        // linger a little at full and at empty before turning round
        if (growing && dir_board.used >= MaxSlots && $urandom_range(7) == 0) growing = 1'b0;
        else if (!growing && dir_board.used == 0 && $urandom_range(3) == 0) growing = 1'b1;
        send_req(random_req(growing));
      end
    end
    req_if.valid <= 1'b0;

    while (dir_board.due_rsp.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (dir_board.mismatches == 0) begin
      $display("slot_directory_insert_remove_tb: PASS");
    end else begin
      $display("slot_directory_insert_remove_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
hdl/sdir_pkg.sv
hdl/sdir_stream_if.sv
hdl/sdir_cell.sv
hdl/slot_directory_insert_remove.sv
tb/slot_directory_insert_remove_tb.sv
